// ----- src/stmc_pkg.sv -----
package stmc_pkg;

    // field widths fixed by the item formats
    localparam int FUNC_BITS   = 1;
    localparam int IDX_BITS    = 5;
    localparam int VTX_BITS    = 5;
    localparam int WFIELD_BITS = 16;
    localparam int MASK_BITS   = 32;
    localparam int SUM_BITS    = 21;
    localparam int CFG_BITS    = 6;
    localparam int CNT_BITS    = 6;
    localparam int VIS_BITS    = 1 << VTX_BITS;

    // APB port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // parameter defaults
    localparam int DEF_MAX_EDGES    = 32;
    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_WEIGHT_BITS  = 16;

    // item function codes
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD = 1'b0;
    localparam logic [FUNC_BITS-1:0] FUNC_EVAL = 1'b1;

    // register word indexes
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT   = 1'b1;

    localparam logic [CFG_BITS-1:0] RST_VERTEX_COUNT = 6'd1;
    localparam logic [CFG_BITS-1:0] RST_EDGE_COUNT   = 6'd0;

    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [IDX_BITS-1:0]    edge_index;
        logic [VTX_BITS-1:0]    endpoint_a;
        logic [VTX_BITS-1:0]    endpoint_b;
        logic [WFIELD_BITS-1:0] weight_a;
        logic [WFIELD_BITS-1:0] weight_b;
        logic [MASK_BITS-1:0]   edge_mask;
    } t_in_item;

    typedef struct packed {
        logic                count_ok;
        logic                reached_all;
        logic                is_spanning_tree;
        logic [SUM_BITS-1:0] sum_a;
        logic [SUM_BITS-1:0] sum_b;
    } t_out_item;

    typedef struct packed {
        logic [CFG_BITS-1:0] vertex_count;
        logic [CFG_BITS-1:0] edge_count;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

// ----- src/stmc_ram.sv -----
module stmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/stmc_regs.sv -----
module stmc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stmc_pkg::APB_AW-1:0]   paddr,
    input  logic [stmc_pkg::APB_DW-1:0]   pwdata,
    output logic [stmc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output stmc_pkg::t_cfg                o_cfg
);

    stmc_pkg::t_cfg r_cfg;
    stmc_pkg::t_cfg n_cfg;
    logic           wr_en;
    logic           word;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign word   = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (word)
                stmc_pkg::REG_VERTEX_COUNT: n_cfg.vertex_count = pwdata[stmc_pkg::CFG_BITS-1:0];
                stmc_pkg::REG_EDGE_COUNT:   n_cfg.edge_count   = pwdata[stmc_pkg::CFG_BITS-1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertex_count <= stmc_pkg::RST_VERTEX_COUNT;
            r_cfg.edge_count   <= stmc_pkg::RST_EDGE_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (word)
            stmc_pkg::REG_VERTEX_COUNT:
                prdata = {{(stmc_pkg::APB_DW-stmc_pkg::CFG_BITS){1'b0}}, r_cfg.vertex_count};
            stmc_pkg::REG_EDGE_COUNT:
                prdata = {{(stmc_pkg::APB_DW-stmc_pkg::CFG_BITS){1'b0}}, r_cfg.edge_count};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/stmc_core.sv -----
module stmc_core #(
    parameter int MAX_EDGES    = stmc_pkg::DEF_MAX_EDGES,
    parameter int MAX_VERTICES = stmc_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = stmc_pkg::DEF_WEIGHT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stmc_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  stmc_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output stmc_pkg::t_out_item  o_out_data
);

    localparam int WB     = (WEIGHT_BITS < stmc_pkg::WFIELD_BITS) ?
                            WEIGHT_BITS : stmc_pkg::WFIELD_BITS;
    localparam int AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NE_CAP = (MAX_EDGES < stmc_pkg::MASK_BITS) ? MAX_EDGES : stmc_pkg::MASK_BITS;
    localparam int VB     = stmc_pkg::VTX_BITS;
    localparam int CB     = stmc_pkg::CNT_BITS;
    localparam int SB     = stmc_pkg::SUM_BITS;
    localparam int RW     = 2 * VB + 2 * WB;

    stmc_pkg::t_state                  r_state, n_state;
    logic                              r_eval, n_eval;
    logic [stmc_pkg::MASK_BITS-1:0]    r_mask, n_mask;
    logic [CB-1:0]                     r_nv, n_nv;
    logic [CB-1:0]                     r_ne, n_ne;
    logic [CB-1:0]                     r_iss, n_iss;
    logic                              r_pend, n_pend;
    logic [CB-1:0]                     r_count, n_count;
    logic [SB-1:0]                     r_sum_a, n_sum_a;
    logic [SB-1:0]                     r_sum_b, n_sum_b;
    logic [stmc_pkg::VIS_BITS-1:0]     r_vis, n_vis;
    logic                              r_changed, n_changed;
    logic                              r_out_valid, n_out_valid;
    stmc_pkg::t_out_item               r_out, n_out;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_rdata;

    logic [VB-1:0]     rd_a, rd_b;
    logic [WB-1:0]     rd_wa, rd_wb;
    logic [stmc_pkg::VIS_BITS-1:0] bit_a, bit_b;
    logic              va, vb;

    logic [CB-1:0]     eff_nv, eff_ne;
    logic              in_fire, busy, issue, pass_done, out_free;
    logic [stmc_pkg::VIS_BITS-1:0] need;
    logic              reached, count_ok;

    stmc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_EDGES),
        .AW    (AW)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective counts from the registers
    always_comb begin
        if (i_cfg.vertex_count == '0) begin
            eff_nv = CB'(1);
        end else if ({1'b0, i_cfg.vertex_count} > (CB+1)'(MAX_VERTICES)) begin
            eff_nv = CB'(MAX_VERTICES);
        end else begin
            eff_nv = i_cfg.vertex_count;
        end
        if ({1'b0, i_cfg.edge_count} > (CB+1)'(NE_CAP)) begin
            eff_ne = CB'(NE_CAP);
        end else begin
            eff_ne = i_cfg.edge_count;
        end
    end

    assign {rd_a, rd_b, rd_wa, rd_wb} = ram_rdata;
    assign bit_a = stmc_pkg::VIS_BITS'(1) << rd_a;
    assign bit_b = stmc_pkg::VIS_BITS'(1) << rd_b;
    assign va    = r_vis[rd_a];
    assign vb    = r_vis[rd_b];

    assign o_in_ready = (r_state == stmc_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign busy       = (r_state == stmc_pkg::ST_SCAN) || (r_state == stmc_pkg::ST_WALK);
    assign issue      = busy && (r_iss < r_ne);
    assign pass_done  = busy && (r_iss == r_ne) && !r_pend;
    assign out_free   = !r_out_valid || i_out_ready;

    // coverage of vertices 0..nv-1
    always_comb begin
        for (int i = 0; i < stmc_pkg::VIS_BITS; i++) begin
            need[i] = (CB'(i) < r_nv);
        end
        if (r_count == '0) begin
            reached = (r_nv == CB'(1));
        end else begin
            reached = ((r_vis & need) == need) &&
                      ({1'b0, r_nv} <= (CB+1)'(stmc_pkg::VIS_BITS));
        end
        count_ok = (r_count == (r_nv - CB'(1)));
    end

    always_comb begin
        n_state     = r_state;
        n_eval      = r_eval;
        n_mask      = r_mask;
        n_nv        = r_nv;
        n_ne        = r_ne;
        n_iss       = r_iss;
        n_pend      = 1'b0;
        n_count     = r_count;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_vis       = r_vis;
        n_changed   = r_changed;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        ram_we    = 1'b0;
        ram_waddr = AW'(i_in_data.edge_index);
        ram_wdata = {i_in_data.endpoint_a, i_in_data.endpoint_b,
                     i_in_data.weight_a[WB-1:0], i_in_data.weight_b[WB-1:0]};
        ram_raddr = r_iss[AW-1:0];

        if (issue) begin
            n_iss  = r_iss + CB'(1);
            n_pend = r_mask[r_iss[4:0]];
        end

        case (r_state)
            stmc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_eval = (i_in_data.func == stmc_pkg::FUNC_EVAL);
                    if (i_in_data.func == stmc_pkg::FUNC_EVAL) begin
                        n_mask  = i_in_data.edge_mask;
                        n_nv    = eff_nv;
                        n_ne    = eff_ne;
                        n_iss   = '0;
                        n_count = '0;
                        n_sum_a = '0;
                        n_sum_b = '0;
                        n_vis   = '0;
                        n_state = stmc_pkg::ST_SCAN;
                    end else begin
                        ram_we  = ({2'b00, i_in_data.edge_index} <
                                   (stmc_pkg::IDX_BITS+2)'(MAX_EDGES));
                        n_state = stmc_pkg::ST_DONE;
                    end
                end
            end
            stmc_pkg::ST_SCAN: begin
                if (r_pend) begin
                    n_count = r_count + CB'(1);
                    n_sum_a = r_sum_a + SB'(rd_wa);
                    n_sum_b = r_sum_b + SB'(rd_wb);
                    if (r_count == '0) begin
                        n_vis = bit_a;
                    end
                end
                if (pass_done) begin
                    if (r_count == '0) begin
                        n_state = stmc_pkg::ST_DONE;
                    end else begin
                        n_iss     = '0;
                        n_changed = 1'b0;
                        n_state   = stmc_pkg::ST_WALK;
                    end
                end
            end
            stmc_pkg::ST_WALK: begin
                if (r_pend) begin
                    n_vis     = r_vis | (va ? bit_b : '0) | (vb ? bit_a : '0);
                    n_changed = r_changed || (va ^ vb);
                end
                if (pass_done) begin
                    if (r_changed) begin
                        n_iss     = '0;
                        n_changed = 1'b0;
                    end else begin
                        n_state = stmc_pkg::ST_DONE;
                    end
                end
            end
            stmc_pkg::ST_DONE: begin
                if (out_free) begin
                    if (r_eval) begin
                        n_out.count_ok         = count_ok;
                        n_out.reached_all      = reached;
                        n_out.is_spanning_tree = count_ok && reached;
                        n_out.sum_a            = r_sum_a;
                        n_out.sum_b            = r_sum_b;
                    end else begin
                        n_out = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = stmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stmc_pkg::ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval    <= n_eval;
        r_mask    <= n_mask;
        r_nv      <= n_nv;
        r_ne      <= n_ne;
        r_iss     <= n_iss;
        r_count   <= n_count;
        r_sum_a   <= n_sum_a;
        r_sum_b   <= n_sum_b;
        r_vis     <= n_vis;
        r_changed <= n_changed;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // table is written only between transactions
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == stmc_pkg::ST_IDLE))
        else $error("edge table written during evaluation");

    // read data in flight only while scanning or walking
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> busy)
        else $error("read return outside a pass");

    // issue pointer never runs past the edge count
    a_iss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_iss <= r_ne))
        else $error("issue pointer past edge count");

    // selected count cannot exceed edges issued in the first pass
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stmc_pkg::ST_SCAN) |-> (r_count <= r_iss))
        else $error("edge count ahead of issued reads");

endmodule

// ----- src/spanning_tree_mask_check.sv -----
// Spanning-tree check of an edge subset. Load transactions (func=0) write one
// edge (two endpoints, two 8.8 weights) into an on-chip table; a load to a slot
// at or above MAX_EDGES is dropped. Evaluate transactions (func=1) bring a mask
// in which bit k selects edge k (bits at or above edge_count are ignored) and
// return the selected edge count check, whether a walk from the first endpoint
// of the lowest selected edge reaches every vertex below vertex_count, the
// spanning-tree flag, and both weight sums. Every transaction returns exactly
// one result; loads return all zeros. Selected edges must have been loaded.
// An evaluate makes one pass over the edge table to sum weights, then, if any
// edge is selected, repeats walk passes until a pass reaches no new vertex;
// each pass reads the edges in use one by one through the single read port of
// the table RAM. A finished result sits in an output register, so the next
// transaction is accepted while it waits.
// Registers (APB, byte address 4*i): 0 vertex_count, 1 edge_count (6 bits).
// Write registers only while no transaction is in flight.
module spanning_tree_mask_check #(
    parameter int MAX_EDGES    = stmc_pkg::DEF_MAX_EDGES,
    parameter int MAX_VERTICES = stmc_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = stmc_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stmc_pkg::APB_AW-1:0]  paddr,
    input  logic [stmc_pkg::APB_DW-1:0]  pwdata,
    output logic [stmc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,

    // input transactions
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  stmc_pkg::t_in_item           i_in_data,

    // result transactions
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output stmc_pkg::t_out_item          o_out_data
);

    stmc_pkg::t_cfg cfg;

    // register file: vertex and edge counts
    stmc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // edge table plus scan/walk sequencer
    stmc_core #(
        .MAX_EDGES    (MAX_EDGES),
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
